@@ hw/rtl/xsrm_pkg.sv @@
// Shared types and constants for the xorshift128 generator with range reduction.
// Used by the controller, the datapath and the top level.
`default_nettype none
package xsrm_pkg;

  localparam int WordW  = 32;
  localparam int RangeW = 31;
  localparam int IdxW   = 3;
  localparam int CntW   = 5;

  // xorshift128 shift amounts
  localparam int ShiftA = 11;
  localparam int ShiftB = 19;
  localparam int ShiftC = 8;

  // Seed register reset values
  localparam logic [WordW-1:0] SeedFirstRst  = 32'd123456789;
  localparam logic [WordW-1:0] SeedSecondRst = 32'd362436069;
  localparam logic [WordW-1:0] SeedThirdRst  = 32'd521288629;
  localparam logic [WordW-1:0] SeedFourthRst = 32'd88675123;

  // Register indexes
  localparam logic [IdxW-1:0] RegSeedFirst  = 3'd0;
  localparam logic [IdxW-1:0] RegSeedSecond = 3'd1;
  localparam logic [IdxW-1:0] RegSeedThird  = 3'd2;
  localparam logic [IdxW-1:0] RegSeedFourth = 3'd3;

  // Item actions
  localparam logic ActDraw   = 1'b0;
  localparam logic ActReseed = 1'b1;

  // Last divider step count
  localparam logic [CntW-1:0] CntLast = CntW'(WordW - 1);

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // accept an item: advance or reseed, set up the divider
    logic step;      // one restoring division step
    logic out_load;  // move the result into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_last;  // current step is the final quotient bit
  } stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/xsrm_dpath.sv @@
// Datapath: seed registers, state words, restoring divider and output register.
// Depends on xsrm_pkg; driven by xsrm_ctrl commands.
`default_nettype none
module xsrm_dpath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [xsrm_pkg::IdxW-1:0]   cfg_index,
  input  wire logic [xsrm_pkg::WordW-1:0]  cfg_data,
  input  wire logic                        action,
  input  wire logic [xsrm_pkg::RangeW-1:0] range_size,
  input  wire xsrm_pkg::cmd_t              cmd,
  output xsrm_pkg::stat_t                  stat,
  output logic [xsrm_pkg::RangeW-1:0]      bounded_value,
  output logic [xsrm_pkg::WordW-1:0]       raw_word
);
  import xsrm_pkg::*;

  logic [WordW-1:0]  seed_first, seed_second, seed_third, seed_fourth;
  logic [WordW-1:0]  word_first, word_second, word_third, word_fourth;
  logic [WordW-1:0]  t_mix, word_next;
  logic [WordW-1:0]  dq;
  logic [RangeW-1:0] rem;
  logic [RangeW-1:0] divisor;
  logic [CntW-1:0]   cnt;
  logic              reseed;
  logic [WordW-1:0]  rem_sh, rem_diff;
  logic              rem_ge;

  // Seed registers; writes beyond the last index are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_first  <= SeedFirstRst;
      seed_second <= SeedSecondRst;
      seed_third  <= SeedThirdRst;
      seed_fourth <= SeedFourthRst;
    end else if (cfg_write) begin
      case (cfg_index)
        RegSeedFirst:  seed_first  <= cfg_data;
        RegSeedSecond: seed_second <= cfg_data;
        RegSeedThird:  seed_third  <= cfg_data;
        RegSeedFourth: seed_fourth <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next fourth word of the generator
  always_comb begin
    t_mix     = word_first ^ (word_first << ShiftA);
    word_next = word_fourth ^ (word_fourth >> ShiftB) ^ t_mix ^ (t_mix >> ShiftC);
  end

  // Advance or reload the state words
  always_ff @(posedge clk) begin
    if (rst) begin
      word_first  <= SeedFirstRst;
      word_second <= SeedSecondRst;
      word_third  <= SeedThirdRst;
      word_fourth <= SeedFourthRst;
    end else if (cmd.load) begin
      if (action == ActReseed) begin
        word_first  <= seed_first;
        word_second <= seed_second;
        word_third  <= seed_third;
        word_fourth <= seed_fourth;
      end else begin
        word_first  <= word_second;
        word_second <= word_third;
        word_third  <= word_fourth;
        word_fourth <= word_next;
      end
    end
  end

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh   = {rem, dq[WordW-1]};
    rem_ge   = rem_sh >= {1'b0, divisor};
    rem_diff = rem_sh - {1'b0, divisor};
  end

  // Divider registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dq      <= word_next;
      rem     <= '0;
      cnt     <= '0;
      divisor <= range_size;
      reseed  <= (action == ActReseed);
    end else if (cmd.step) begin
      dq  <= {dq[WordW-2:0], 1'b0};
      rem <= rem_ge ? rem_diff[RangeW-1:0] : rem_sh[RangeW-1:0];
      cnt <= cnt + 1'b1;
    end
  end

  assign stat.div_last = (cnt == CntLast);

  // Output register; zero range and reseed give a zero bounded value
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      bounded_value <= (reseed || divisor == '0) ? '0 : rem;
      raw_word      <= reseed ? '0 : word_fourth;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/xsrm_ctrl.sv @@
// Controller: item handshake, divider sequencing and output valid.
// Depends on xsrm_pkg; commands xsrm_dpath.
`default_nettype none
module xsrm_ctrl (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire logic     action,
  output logic          out_valid,
  input  wire logic     out_stall,
  output xsrm_pkg::cmd_t cmd,
  input  wire xsrm_pkg::stat_t stat
);
  import xsrm_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0] state, state_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != StIdle);

  // Sequence one item at a time
  always_comb begin
    state_next   = state;
    cmd.load     = 1'b0;
    cmd.step     = 1'b0;
    cmd.out_load = 1'b0;
    case (state)
      StIdle: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = (action == ActReseed) ? StDone : StDiv;
        end
      end
      StDiv: begin
        cmd.step = 1'b1;
        if (stat.div_last) state_next = StDone;
      end
      StDone: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = StIdle;
        end
      end
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      state <= state_next;
    end
  end

  // Hold the result valid until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/xorshift128_random_modulo.sv @@
// xorshift128 generator with reduction to a range: top level.
// Sequence: a draw item takes a load, 32 restoring divider steps of one quotient bit each and
// an output load that waits while a held result is stalled; a reseed item skips the divider steps.
// The bit-serial divider accepts no new item until the last result is in the output register.
// Reset: synchronous active-high rst loads the seed registers and state words with their
// default seeds and clears the output valid.
`default_nettype none
module xorshift128_random_modulo (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [xsrm_pkg::IdxW-1:0]   cfg_index,
  input  wire logic [xsrm_pkg::WordW-1:0]  cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        action,
  input  wire logic [xsrm_pkg::RangeW-1:0] range_size,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [xsrm_pkg::RangeW-1:0]      bounded_value,
  output logic [xsrm_pkg::WordW-1:0]       raw_word
);
  import xsrm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencing
  xsrm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Generator, divider and result
  xsrm_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .action        (action),
    .range_size    (range_size),
    .cmd           (cmd),
    .stat          (stat),
    .bounded_value (bounded_value),
    .raw_word      (raw_word)
  );

endmodule
`default_nettype wire
